// ===== rtl/core/es2c_pkg.sv =====
// Shared types, constants and tables for the epoch-seconds to calendar converter.
package es2c_pkg;

	// Divisor constants and their truncated 2^32 reciprocals
	localparam int unsigned DIV_W   = 11;
	localparam int unsigned RECIP_W = 32;
	localparam int unsigned REM_W   = 12;

	localparam logic [DIV_W-1:0] DIV_60   = 11'd60;
	localparam logic [DIV_W-1:0] DIV_24   = 11'd24;
	localparam logic [DIV_W-1:0] DIV_7    = 11'd7;
	localparam logic [DIV_W-1:0] DIV_1461 = 11'd1461;
	localparam logic [DIV_W-1:0] DIV_365  = 11'd365;

	localparam logic [RECIP_W-1:0] RECIP_60   = 32'((64'd1 << 32) / 64'd60);
	localparam logic [RECIP_W-1:0] RECIP_24   = 32'((64'd1 << 32) / 64'd24);
	localparam logic [RECIP_W-1:0] RECIP_7    = 32'((64'd1 << 32) / 64'd7);
	localparam logic [RECIP_W-1:0] RECIP_1461 = 32'((64'd1 << 32) / 64'd1461);
	localparam logic [RECIP_W-1:0] RECIP_365  = 32'((64'd1 << 32) / 64'd365);

	// Calendar constants
	localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
	localparam logic [31:0] WEEKDAY_BIAS      = 32'd4;
	localparam logic [10:0] LEAP_DAY_OFFSET   = 11'd60;
	localparam logic [10:0] DAYS_PER_YEAR     = 11'd365;
	localparam logic [11:0] YEAR_BASE         = 12'd1968;
	localparam logic [3:0]  MONTH_JAN         = 4'd1;
	localparam logic [3:0]  MONTH_FEB         = 4'd2;
	localparam logic [3:0]  MONTH_DEC         = 4'd12;

	// Request into the shared divide unit
	typedef struct packed {
		logic               start;
		logic [31:0]        x;
		logic [DIV_W-1:0]   d;
		logic [RECIP_W-1:0] m;
	} div_req_t;

	// Status out of the shared divide unit
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [31:0]      q;
		logic [REM_W-1:0] r;
	} div_rsp_t;

	typedef enum logic [2:0] {
		DIV_IDLE,
		DIV_MUL_EST,
		DIV_MUL_BACK,
		DIV_SUB,
		DIV_FIX
	} div_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEC,
		ST_MIN,
		ST_HOUR,
		ST_WDAY,
		ST_PERIOD,
		ST_YEAR,
		ST_MONTH,
		ST_FINISH
	} conv_state_t;

	// First day of year of each month, non-leap year
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd59;
			4'd3:    v = 9'd90;
			4'd4:    v = 9'd120;
			4'd5:    v = 9'd151;
			4'd6:    v = 9'd181;
			4'd7:    v = 9'd212;
			4'd8:    v = 9'd243;
			4'd9:    v = 9'd273;
			4'd10:   v = 9'd304;
			4'd11:   v = 9'd334;
			default: v = 9'd365;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/es2c_cdiv.sv =====
// Shared divide-by-constant unit: reciprocal multiply, back multiply, subtract, correct.
module es2c_cdiv (
	input  logic               clk,
	input  logic               arst_n,
	input  es2c_pkg::div_req_t req,
	output es2c_pkg::div_rsp_t rsp
);
	import es2c_pkg::*;

	div_phase_t         phase_q, phase_nxt;
	logic [31:0]        x_q;
	logic [DIV_W-1:0]   d_q;
	logic [RECIP_W-1:0] m_q;
	logic [63:0]        prod_q;
	logic [31:0]        q_q;
	logic [REM_W-1:0]   r_q;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        prod;
	logic               fix;

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DIV_IDLE;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	// Advance through the fixed phase sequence
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			DIV_IDLE:     if (req.start) phase_nxt = DIV_MUL_EST;
			DIV_MUL_EST:  phase_nxt = DIV_MUL_BACK;
			DIV_MUL_BACK: phase_nxt = DIV_SUB;
			DIV_SUB:      phase_nxt = DIV_FIX;
			DIV_FIX:      phase_nxt = DIV_IDLE;
			default:      phase_nxt = DIV_IDLE;
		endcase
	end

	// One multiplier: x * reciprocal first, then estimate * divisor
	assign mul_a = (phase_q == DIV_MUL_EST) ? x_q : prod_q[63:32];
	assign mul_b = (phase_q == DIV_MUL_EST) ? m_q : {{(32-DIV_W){1'b0}}, d_q};
	assign prod  = 64'(mul_a) * 64'(mul_b);

	// Operand and intermediate registers
	always_ff @(posedge clk) begin
		case (phase_q)
			DIV_IDLE: begin
				if (req.start) begin
					x_q <= req.x;
					d_q <= req.d;
					m_q <= req.m;
				end
			end
			DIV_MUL_EST: begin
				prod_q <= prod;
			end
			DIV_MUL_BACK: begin
				q_q    <= prod_q[63:32];
				prod_q <= prod;
			end
			DIV_SUB: begin
				r_q <= REM_W'(x_q - prod_q[31:0]);
			end
			default: begin
			end
		endcase
	end

	// Estimate is low by at most one: correct once
	assign fix      = (r_q >= {1'b0, d_q});
	assign rsp.q    = q_q + 32'(fix);
	assign rsp.r    = fix ? (r_q - {1'b0, d_q}) : r_q;
	assign rsp.done = (phase_q == DIV_FIX);
	assign rsp.idle = (phase_q == DIV_IDLE);

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_core.sv =====
// Epoch-seconds to calendar date converter, top level.
//
// Usage: present a 32-bit count of seconds since 1970-01-01 00:00:00 on
// epoch_seconds with in_valid; it is taken when in_valid and in_ready are
// both high. One result comes back on the out_* fields with out_valid and
// is taken when out_valid and out_ready are both high. Every input gives
// exactly one result. Leap years are every fourth year (no century rule).
// The sequencer runs six divisions by constants through one shared
// multiply/subtract unit, each as estimate, back multiply, subtract and
// correct, then the month search walks down from December one month a cycle.
// in_ready is high only while the sequencer is idle, so no new item is taken
// mid-conversion. The finished result sits in an output register, so
// the next item is accepted while the previous result still waits.
// Stall: if the output register still holds a result that out_ready has
// not yet taken, the sequencer holds the new result until it frees up.
// Reset: arst_n clears the sequencer, divider phase and out_valid only.
module epoch_seconds_to_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  sec_of_minute,
	output logic [5:0]  min_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_index,
	output logic [11:0] full_year,
	output logic [2:0]  weekday,
	output logic [8:0]  day_of_year
);
	import es2c_pkg::*;

	conv_state_t state_q, state_nxt;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	logic [31:0] secs_q;
	logic [31:0] work_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [15:0] days_q;
	logic [2:0]  wday_q;
	logic [10:0] rem_q;
	logic [5:0]  leaps_q;
	logic [7:0]  years_q;
	logic [8:0]  doy_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;

	logic        out_valid_q;
	logic [5:0]  sec_of_minute_q;
	logic [5:0]  min_of_hour_q;
	logic [4:0]  hour_of_day_q;
	logic [4:0]  day_of_month_q;
	logic [3:0]  month_index_q;
	logic [11:0] full_year_q;
	logic [2:0]  weekday_q;
	logic [8:0]  day_of_year_q;

	logic [15:0] d68;
	logic        leap;
	logic [8:0]  mstart;
	logic        month_hit;
	logic        load_out;
	logic        in_leap_window;

	es2c_cdiv u_cdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Derived day counts and the month compare
	assign d68            = days_q + DAYS_1968_TO_1970;
	assign leap           = (years_q[1:0] == 2'd0);
	assign mstart         = month_start(month_q - 4'd1) +
	                        9'((month_q > MONTH_FEB) && leap);
	assign month_hit      = (doy_q >= mstart) || (month_q == MONTH_JAN);
	assign in_leap_window = (rem_q >= LEAP_DAY_OFFSET) && (rem_q <= DAYS_PER_YEAR);
	assign load_out       = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Select divide operands for the current step
	always_comb begin
		div_req.start = 1'b0;
		div_req.x     = work_q;
		div_req.d     = DIV_60;
		div_req.m     = RECIP_60;
		case (state_q)
			ST_SEC: begin
				div_req.x = secs_q;
			end
			ST_MIN: begin
				div_req.x = work_q;
			end
			ST_HOUR: begin
				div_req.d = DIV_24;
				div_req.m = RECIP_24;
			end
			ST_WDAY: begin
				div_req.x = 32'(days_q) + WEEKDAY_BIAS;
				div_req.d = DIV_7;
				div_req.m = RECIP_7;
			end
			ST_PERIOD: begin
				div_req.x = 32'(d68);
				div_req.d = DIV_1461;
				div_req.m = RECIP_1461;
			end
			ST_YEAR: begin
				div_req.x = 32'(d68 - 16'(leaps_q));
				div_req.d = DIV_365;
				div_req.m = RECIP_365;
			end
			default: begin
			end
		endcase
		if (state_q inside {ST_SEC, ST_MIN, ST_HOUR, ST_WDAY, ST_PERIOD, ST_YEAR}) begin
			div_req.start = div_rsp.idle;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_nxt = ST_SEC;
			end
			ST_SEC:    if (div_rsp.done) state_nxt = ST_MIN;
			ST_MIN:    if (div_rsp.done) state_nxt = ST_HOUR;
			ST_HOUR:   if (div_rsp.done) state_nxt = ST_WDAY;
			ST_WDAY:   if (div_rsp.done) state_nxt = ST_PERIOD;
			ST_PERIOD: if (div_rsp.done) state_nxt = ST_YEAR;
			ST_YEAR:   if (div_rsp.done) state_nxt = ST_MONTH;
			ST_MONTH:  if (month_hit) state_nxt = ST_FINISH;
			ST_FINISH: if (load_out) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Capture each step's results
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) secs_q <= epoch_seconds;
			end
			ST_SEC: begin
				if (div_rsp.done) begin
					sec_q  <= div_rsp.r[5:0];
					work_q <= div_rsp.q;
				end
			end
			ST_MIN: begin
				if (div_rsp.done) begin
					min_q  <= div_rsp.r[5:0];
					work_q <= div_rsp.q;
				end
			end
			ST_HOUR: begin
				if (div_rsp.done) begin
					hour_q <= div_rsp.r[4:0];
					days_q <= div_rsp.q[15:0];
				end
			end
			ST_WDAY: begin
				if (div_rsp.done) wday_q <= div_rsp.r[2:0];
			end
			ST_PERIOD: begin
				if (div_rsp.done) begin
					rem_q   <= div_rsp.r[10:0];
					leaps_q <= div_rsp.q[5:0] + 6'(div_rsp.r[10:0] >= LEAP_DAY_OFFSET);
				end
			end
			ST_YEAR: begin
				if (div_rsp.done) begin
					years_q <= div_rsp.q[7:0];
					doy_q   <= div_rsp.r[8:0] + 9'(in_leap_window);
					month_q <= MONTH_DEC;
				end
			end
			ST_MONTH: begin
				if (month_hit) begin
					day_q <= 5'(doy_q - mstart + 9'd1);
				end else begin
					month_q <= month_q - 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			sec_of_minute_q <= sec_q;
			min_of_hour_q   <= min_q;
			hour_of_day_q   <= hour_q;
			day_of_month_q  <= day_q;
			month_index_q   <= month_q - 4'd1;
			full_year_q     <= 12'(years_q) + YEAR_BASE;
			weekday_q       <= wday_q;
			day_of_year_q   <= doy_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sec_of_minute = sec_of_minute_q;
	assign min_of_hour   = min_of_hour_q;
	assign hour_of_day   = hour_of_day_q;
	assign day_of_month  = day_of_month_q;
	assign month_index   = month_index_q;
	assign full_year     = full_year_q;
	assign weekday       = weekday_q;
	assign day_of_year   = day_of_year_q;

endmodule

// ===== bench/epoch_seconds_to_calendar_core_test.sv =====
// Self-checking testbench for the epoch-seconds to calendar date converter.
module epoch_seconds_to_calendar_core_test;

	localparam int unsigned SECS_PER_MIN  = 60;
	localparam int unsigned MINS_PER_HOUR = 60;
	localparam int unsigned HOURS_PER_DAY = 24;
	localparam int unsigned SECS_PER_DAY  = 86400;
	localparam int unsigned EPOCH_OFFSET  = 731;   // days from 1968-01-01 to 1970-01-01
	localparam int unsigned LEAP_CYCLE    = 1461;  // days in four years
	localparam int unsigned FEB29_DAY     = 60;    // day within a leap cycle after Feb 29
	localparam int unsigned YEAR_DAYS     = 365;
	localparam int unsigned FIRST_YEAR    = 1968;
	localparam int unsigned MAX_DAY       = 49709; // last whole day below 2^32 seconds
	localparam int          DIRECTED_ROWS = 24;
	localparam int          RANDOM_ITEMS  = 1526;
	localparam int          SETTLE_CYCLES = 60;

	// Calendar fields at the widths of the output ports
	typedef struct packed {
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [4:0]  mday;
		logic [3:0]  mon;
		logic [11:0] year;
		logic [2:0]  wday;
		logic [8:0]  yday;
	} calendar_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic        typed;
		calendar_t   result;
	} stim_row_t;

	// First day of year of each month in a common year
	localparam int unsigned MONTH_FIRST_DAY [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  sec_of_minute;
	logic [5:0]  min_of_hour;
	logic [4:0]  hour_of_day;
	logic [4:0]  day_of_month;
	logic [3:0]  month_index;
	logic [11:0] full_year;
	logic [2:0]  weekday;
	logic [8:0]  day_of_year;

	calendar_t pending_dates [$];
	stim_row_t directed_rows [DIRECTED_ROWS];
	int        mismatch_count = 0;
	int        burst_left     = 0;
	int        ready_mode     = 0;
	int        mode_left      = 0;
	int        stall_left     = 0;

	epoch_seconds_to_calendar_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sec_of_minute (sec_of_minute),
		.min_of_hour   (min_of_hour),
		.hour_of_day   (hour_of_day),
		.day_of_month  (day_of_month),
		.month_index   (month_index),
		.full_year     (full_year),
		.weekday       (weekday),
		.day_of_year   (day_of_year)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Split a second count into a date, treating every fourth year as leap
	function automatic calendar_t calendar_of_seconds(input logic [31:0] secs);
		logic [31:0] mins_total;
		logic [31:0] hours_total;
		logic [31:0] days;
		logic [31:0] days_1968;
		logic [31:0] cycle_rem;
		logic [31:0] leap_days;
		logic [31:0] year_count;
		logic [31:0] yday;
		logic [31:0] year;
		logic [31:0] start;
		logic [31:0] leap;
		int          month;
		calendar_t   c;
		mins_total  = secs / SECS_PER_MIN;
		hours_total = mins_total / MINS_PER_HOUR;
		days        = hours_total / HOURS_PER_DAY;
		c.sec       = 6'(secs - mins_total * SECS_PER_MIN);
		c.min       = 6'(mins_total - hours_total * MINS_PER_HOUR);
		c.hour      = 5'(hours_total - days * HOURS_PER_DAY);
		c.wday      = 3'((days + 4) % 7);

		// Count leap days passed since 1968, then whole years
		days_1968 = days + EPOCH_OFFSET;
		leap_days = days_1968 / LEAP_CYCLE;
		cycle_rem = days_1968 % LEAP_CYCLE;
		if (cycle_rem >= FEB29_DAY) begin
			leap_days++;
		end
		year_count = (days_1968 - leap_days) / YEAR_DAYS;
		yday       = days_1968 - year_count * YEAR_DAYS - leap_days;
		if (cycle_rem <= YEAR_DAYS && cycle_rem >= FEB29_DAY) begin
			yday++;
		end
		year = year_count + FIRST_YEAR;
		leap = (year[1:0] == 2'b00) ? 32'd1 : 32'd0;

		// Walk down from December to the month holding the day
		month = 12;
		start = MONTH_FIRST_DAY[11] + leap;
		while (month > 1 && yday < start) begin
			month--;
			start = MONTH_FIRST_DAY[month - 1] + ((month > 2) ? leap : 32'd0);
		end
		c.mday = 5'(yday - start + 1);
		c.mon  = 4'(month - 1);
		c.year = 12'(year);
		c.yday = 9'(yday);
		return c;
	endfunction

	// Pick a count: raw, on a day edge, near a year edge or leap day, or past 2100
	function automatic logic [31:0] random_seconds();
		logic [31:0] s;
		longint      base;
		longint      total;
		int          y;
		int          yy;
		int          offset;
		int unsigned tod;
		case ($urandom_range(0, 3))
			0: s = $urandom;
			1: begin
				case ($urandom_range(0, 7))
					0: tod = 0;
					1: tod = 1;
					2: tod = 59;
					3: tod = 60;
					4: tod = 3599;
					5: tod = 3600;
					6: tod = SECS_PER_DAY - 1;
					default: tod = $urandom_range(0, SECS_PER_DAY - 1);
				endcase
				s = $urandom_range(0, MAX_DAY) * SECS_PER_DAY + tod;
			end
			2: begin
				y    = $urandom_range(1970, 2106);
				base = 0;
				for (yy = 1970; yy < y; yy++) begin
					base += (yy % 4 == 0) ? 366 : 365;
				end
				case ($urandom_range(0, 6))
					0: offset = -1;
					1: offset = 0;
					2: offset = 58;
					3: offset = 59;
					4: offset = 60;
					5: offset = 364;
					default: offset = 365;
				endcase
				base += offset;
				if (base < 0) begin
					base = 0;
				end
				total = base * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
				if (total > 64'd4294967295) begin
					s = 32'hFFFF_FFFF - $urandom_range(0, SECS_PER_DAY - 1);
				end else begin
					s = total[31:0];
				end
			end
			default: s = 32'd4102444800 + $urandom_range(0, 192522495);
		endcase
		return s;
	endfunction

	// Compare one accepted result with the date expected for it
	task automatic check_result(input calendar_t want);
		logic bad;
		bad = 1'b0;
		if (sec_of_minute !== want.sec) begin
			$error("sec_of_minute: expected %0d, got %0d", want.sec, sec_of_minute);
			bad = 1'b1;
		end
		if (min_of_hour !== want.min) begin
			$error("min_of_hour: expected %0d, got %0d", want.min, min_of_hour);
			bad = 1'b1;
		end
		if (hour_of_day !== want.hour) begin
			$error("hour_of_day: expected %0d, got %0d", want.hour, hour_of_day);
			bad = 1'b1;
		end
		if (day_of_month !== want.mday) begin
			$error("day_of_month: expected %0d, got %0d", want.mday, day_of_month);
			bad = 1'b1;
		end
		if (month_index !== want.mon) begin
			$error("month_index: expected %0d, got %0d", want.mon, month_index);
			bad = 1'b1;
		end
		if (full_year !== want.year) begin
			$error("full_year: expected %0d, got %0d", want.year, full_year);
			bad = 1'b1;
		end
		if (weekday !== want.wday) begin
			$error("weekday: expected %0d, got %0d", want.wday, weekday);
			bad = 1'b1;
		end
		if (day_of_year !== want.yday) begin
			$error("day_of_year: expected %0d, got %0d", want.yday, day_of_year);
			bad = 1'b1;
		end
		if (bad) begin
			mismatch_count++;
		end
	endtask

	// Offer one item, hold it until taken, and queue its date
	task automatic send_seconds(input stim_row_t row);
		in_valid      <= 1'b1;
		epoch_seconds <= row.seconds;
		do @(posedge clk); while (!in_ready);
		pending_dates.push_back(row.typed ? row.result : calendar_of_seconds(row.seconds));
	endtask

	// Drop valid between bursts, or hold off until every result is back
	task automatic pace_sender(input bit drain);
		int gap;
		if (drain) begin
			in_valid <= 1'b0;
			while (pending_dates.size() != 0) @(posedge clk);
			burst_left = 0;
		end else begin
			if (burst_left > 0) begin
				burst_left--;
			end
			if (burst_left == 0) begin
				gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
				                                         : $urandom_range(1, 6);
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				                                         : $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Check each result taken, then pick the next receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_dates.size() == 0) begin
				$error("result with no item pending");
				mismatch_count++;
			end else begin
				check_result(pending_dates.pop_front());
			end
		end
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(100, 400);
		end
		mode_left--;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: begin
				if (stall_left > 0) begin
					out_ready <= 1'b0;
					stall_left--;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 3) == 0) begin
						stall_left = $urandom_range(1, 40);
					end
				end
			end
		endcase
	end

	// Directed rows; only the epoch, the first day's end and the top count carry dates
	initial begin
		directed_rows = '{
			'{32'd0,          1'b1, '{6'd0,  6'd0,  5'd0,  5'd1, 4'd0, 12'd1970, 3'd4, 9'd0}},
			'{32'd1,          1'b0, '0},
			'{32'd59,         1'b0, '0},
			'{32'd60,         1'b0, '0},
			'{32'd3599,       1'b0, '0},
			'{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 5'd1, 4'd0, 12'd1970, 3'd4, 9'd0}},
			'{32'd86400,      1'b0, '0},
			'{32'd5097600,    1'b0, '0},
			'{32'd31535999,   1'b0, '0},
			'{32'd31536000,   1'b0, '0},
			'{32'd68169600,   1'b0, '0},
			'{32'd94608000,   1'b0, '0},
			'{32'd94694400,   1'b0, '0},
			'{32'd951782400,  1'b0, '0},
			'{32'd1709251200, 1'b0, '0},
			'{32'd1735603200, 1'b0, '0},
			'{32'd2147483647, 1'b0, '0},
			'{32'd2147483648, 1'b0, '0},
			'{32'd4102444799, 1'b0, '0},
			'{32'd4107456000, 1'b0, '0},
			'{32'd4107542400, 1'b0, '0},
			'{32'hFFFF_FFFF,  1'b1, '{6'd15, 6'd28, 5'd6, 5'd6, 4'd1, 12'd2106, 3'd0, 9'd36}},
			'{32'h5555_5555,  1'b0, '0},
			'{32'hAAAA_AAAA,  1'b0, '0}
		};
	end

	// Reset, run the directed rows, then the random items, then settle
	initial begin
		stim_row_t row;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		epoch_seconds = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_seconds(directed_rows[i]);
			pace_sender(i == DIRECTED_ROWS - 1);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			row.seconds = random_seconds();
			row.typed   = 1'b0;
			row.result  = '0;
			send_seconds(row);
			pace_sender(n == RANDOM_ITEMS / 2 || n == RANDOM_ITEMS - 1);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/es2c_pkg.sv
rtl/core/es2c_cdiv.sv
rtl/core/epoch_seconds_to_calendar_core.sv
bench/epoch_seconds_to_calendar_core_test.sv
